/* src/sdtq_pkg.sv */
// Shared types and constants of the sorted deadline timer queue.
// Used by sdtq_cell and sorted_deadline_timer_queue; depends on nothing.
package sdtq_pkg;

    // Input function codes.
    localparam logic [1:0] FUNC_ARM_ABS = 2'd0;
    localparam logic [1:0] FUNC_ARM_REL = 2'd1;
    localparam logic [1:0] FUNC_DROP    = 2'd2;
    localparam logic [1:0] FUNC_POLL    = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_ARMED   = 3'd0;
    localparam logic [2:0] KIND_FULL    = 3'd1;
    localparam logic [2:0] KIND_DROPPED = 3'd2;
    localparam logic [2:0] KIND_ABSENT  = 3'd3;
    localparam logic [2:0] KIND_EXPIRED = 3'd4;
    localparam logic [2:0] KIND_NONE    = 3'd5;

    localparam int MS_TO_US = 1000;
    localparam int PROD_W   = 42;
    localparam int MAX_OUT  = 16;
    localparam int NCNT_W   = $clog2(MAX_OUT + 1);

    // Operation broadcast to every cell of the chain.
    typedef logic [2:0] cell_op_t;
    localparam cell_op_t OP_HOLD    = 3'd0;
    localparam cell_op_t OP_INSERT  = 3'd1;
    localparam cell_op_t OP_DROP    = 3'd2;
    localparam cell_op_t OP_COMPACT = 3'd3;
    localparam cell_op_t OP_POP     = 3'd4;

    typedef struct packed {
        cell_op_t    op;
        logic [63:0] key;      // new deadline on insert, current time on poll
        logic        timeout;  // timeout-path flag of an inserted timer
    } cell_ctrl_t;

endpackage

/* src/sorted_deadline_timer_queue.sv */
// Absolute arm inserts directly; relative arm steps through multiply, add and insert; drop
// is followed by hole compaction before the next transaction; poll gives one result per
// expired timer (at most 16; none due gives one result), one result a cycle while the output
// is not stalled. One item at a time: a new transaction is taken only once the last is done.
// Reset clears the cell valid bits, slot bitmap, state, counters and output valid flag.
module sorted_deadline_timer_queue #(
    parameter int DEPTH     = 16,
    parameter int TAG_WIDTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [63:0] deadline,
    input  logic [31:0] delay_ms,
    input  logic [63:0] now,
    input  logic [7:0]  owner_tag,
    input  logic        timeout_path,
    input  logic [3:0]  handle,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [3:0]  timer_handle,
    output logic [7:0]  expired_tag,
    output logic        expired_timeout,
    output logic        last
);

    localparam int SLOT_W = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MUL     = 3'd1;
    localparam logic [2:0] S_ADD     = 3'd2;
    localparam logic [2:0] S_ARM     = 3'd3;
    localparam logic [2:0] S_DROP    = 3'd4;
    localparam logic [2:0] S_COMPACT = 3'd5;
    localparam logic [2:0] S_POLL    = 3'd6;

    logic [2:0]                   state_reg, state_next;
    logic [63:0]                  key_reg, key_next;
    logic [63:0]                  now_reg, now_next;
    logic [31:0]                  delay_reg, delay_next;
    logic [sdtq_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [TAG_WIDTH-1:0]         tag_reg, tag_next;
    logic                         timeout_reg, timeout_next;
    logic [3:0]                   handle_reg, handle_next;
    logic [SLOT_W-1:0]            cnt_reg, cnt_next;
    logic [sdtq_pkg::NCNT_W-1:0]  npop_reg, npop_next;
    logic [DEPTH-1:0]             used_reg, used_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  kind_reg, kind_next;
    logic [3:0]  handle_out_reg, handle_out_next;
    logic [7:0]  etag_reg, etag_next;
    logic        eto_reg, eto_next;
    logic        last_reg, last_next;

    sdtq_pkg::cell_ctrl_t ctrl;
    logic [SLOT_W-1:0]    cell_slot_in;

    logic                 c_valid   [DEPTH];
    logic [63:0]          c_deadline[DEPTH];
    logic [TAG_WIDTH-1:0] c_tag     [DEPTH];
    logic                 c_timeout [DEPTH];
    logic [SLOT_W-1:0]    c_slot    [DEPTH];
    logic                 c_ins     [DEPTH];
    logic                 c_due     [DEPTH];

    // Lowest free slot.
    logic [DEPTH-1:0]  free_vec, free_onehot;
    logic [SLOT_W-1:0] alloc_slot;

    always_comb
    begin
        free_vec    = ~used_reg;
        free_onehot = free_vec & (~free_vec + 1'b1);
        alloc_slot  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (free_onehot[i])
                alloc_slot = alloc_slot | SLOT_W'(i);
        end
    end

    logic [SLOT_W+3:0]   drop_wide;
    logic [SLOT_W-1:0]   drop_slot;
    logic                drop_hit;
    logic [SLOT_W+3:0]   alloc_wide;
    logic [SLOT_W+3:0]   head_wide;
    logic [TAG_WIDTH+7:0] head_tag_wide;
    logic [TAG_WIDTH+7:0] in_tag_wide;
    logic                out_free;
    logic                full;
    logic                pop_last;

    assign drop_wide     = {{SLOT_W{1'b0}}, handle_reg};
    assign drop_slot     = drop_wide[SLOT_W-1:0];
    assign drop_hit      = (32'(handle_reg) < DEPTH) && used_reg[drop_slot];
    assign alloc_wide    = {4'b0, alloc_slot};
    assign head_wide     = {4'b0, c_slot[0]};
    assign head_tag_wide = {8'b0, c_tag[0]};
    assign in_tag_wide   = {{TAG_WIDTH{1'b0}}, owner_tag};
    assign out_free      = !out_valid_reg || out_ready;
    assign full          = c_valid[DEPTH-1];
    assign pop_last      = (npop_reg == sdtq_pkg::NCNT_W'(sdtq_pkg::MAX_OUT - 1)) || !c_due[1];
    assign cell_slot_in  = (state_reg == S_DROP) ? drop_slot : alloc_slot;

    always_comb
    begin
        state_next      = state_reg;
        key_next        = key_reg;
        now_next        = now_reg;
        delay_next      = delay_reg;
        prod_next       = prod_reg;
        tag_next        = tag_reg;
        timeout_next    = timeout_reg;
        handle_next     = handle_reg;
        cnt_next        = cnt_reg;
        npop_next       = npop_reg;
        used_next       = used_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        handle_out_next = handle_out_reg;
        etag_next       = etag_reg;
        eto_next        = eto_reg;
        last_next       = last_reg;
        ctrl.op         = sdtq_pkg::OP_HOLD;
        ctrl.key        = (state_reg == S_POLL) ? now_reg : key_reg;
        ctrl.timeout    = timeout_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next     = deadline;
                    now_next     = now;
                    delay_next   = delay_ms;
                    tag_next     = in_tag_wide[TAG_WIDTH-1:0];
                    timeout_next = timeout_path;
                    handle_next  = handle;
                    npop_next    = '0;
                    case (func)
                        sdtq_pkg::FUNC_ARM_ABS: state_next = S_ARM;
                        sdtq_pkg::FUNC_ARM_REL: state_next = S_MUL;
                        sdtq_pkg::FUNC_DROP:    state_next = S_DROP;
                        default:                state_next = S_POLL;
                    endcase
                end
            end
            S_MUL:
            begin
                prod_next  = sdtq_pkg::PROD_W'(delay_reg) *
                             sdtq_pkg::PROD_W'(sdtq_pkg::MS_TO_US);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                key_next   = now_reg + 64'(prod_reg);
                state_next = S_ARM;
            end
            S_ARM:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    etag_next      = '0;
                    eto_next       = 1'b0;
                    last_next      = 1'b1;
                    if (full)
                    begin
                        kind_next       = sdtq_pkg::KIND_FULL;
                        handle_out_next = '0;
                    end
                    else
                    begin
                        kind_next             = sdtq_pkg::KIND_ARMED;
                        handle_out_next       = alloc_wide[3:0];
                        used_next[alloc_slot] = 1'b1;
                        ctrl.op               = sdtq_pkg::OP_INSERT;
                    end
                    state_next = S_IDLE;
                end
            end
            S_DROP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    handle_out_next = handle_reg;
                    etag_next       = '0;
                    eto_next        = 1'b0;
                    last_next       = 1'b1;
                    if (drop_hit)
                    begin
                        kind_next            = sdtq_pkg::KIND_DROPPED;
                        used_next[drop_slot] = 1'b0;
                        ctrl.op              = sdtq_pkg::OP_DROP;
                        cnt_next             = SLOT_W'(DEPTH - 2);
                        state_next           = S_COMPACT;
                    end
                    else
                    begin
                        kind_next  = sdtq_pkg::KIND_ABSENT;
                        state_next = S_IDLE;
                    end
                end
            end
            S_COMPACT:
            begin
                ctrl.op  = sdtq_pkg::OP_COMPACT;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_IDLE;
            end
            S_POLL:
            begin
                if (out_free)
                begin
                    if (c_due[0])
                    begin
                        out_valid_next       = 1'b1;
                        kind_next            = sdtq_pkg::KIND_EXPIRED;
                        handle_out_next      = head_wide[3:0];
                        etag_next            = head_tag_wide[7:0];
                        eto_next             = c_timeout[0];
                        last_next            = pop_last;
                        used_next[c_slot[0]] = 1'b0;
                        ctrl.op              = sdtq_pkg::OP_POP;
                        npop_next            = npop_reg + 1'b1;
                        if (pop_last)
                            state_next = S_IDLE;
                    end
                    else
                    begin
                        // Only reached on the first look: later heads were checked ahead.
                        out_valid_next  = 1'b1;
                        kind_next       = sdtq_pkg::KIND_NONE;
                        handle_out_next = '0;
                        etag_next       = '0;
                        eto_next        = 1'b0;
                        last_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                 l_ins, l_valid, l_timeout;
            logic [63:0]          l_deadline;
            logic [TAG_WIDTH-1:0] l_tag;
            logic [SLOT_W-1:0]    l_slot;
            logic                 r_valid, r_timeout;
            logic [63:0]          r_deadline;
            logic [TAG_WIDTH-1:0] r_tag;
            logic [SLOT_W-1:0]    r_slot;

            if (gi == 0)
            begin : g_head
                // The head sees a full neighbor on its left, so it never
                // shifts in from there and never mistakes itself for a hole follower.
                assign l_ins      = 1'b0;
                assign l_valid    = 1'b1;
                assign l_deadline = '0;
                assign l_tag      = '0;
                assign l_timeout  = 1'b0;
                assign l_slot     = '0;
            end
            else
            begin : g_body
                assign l_ins      = c_ins[gi-1];
                assign l_valid    = c_valid[gi-1];
                assign l_deadline = c_deadline[gi-1];
                assign l_tag      = c_tag[gi-1];
                assign l_timeout  = c_timeout[gi-1];
                assign l_slot     = c_slot[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign r_valid    = 1'b0;
                assign r_deadline = '0;
                assign r_tag      = '0;
                assign r_timeout  = 1'b0;
                assign r_slot     = '0;
            end
            else
            begin : g_inner
                assign r_valid    = c_valid[gi+1];
                assign r_deadline = c_deadline[gi+1];
                assign r_tag      = c_tag[gi+1];
                assign r_timeout  = c_timeout[gi+1];
                assign r_slot     = c_slot[gi+1];
            end

            sdtq_cell #(
                .TAG_WIDTH (TAG_WIDTH),
                .SLOT_W    (SLOT_W)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .ctrl           (ctrl),
                .new_tag        (tag_reg),
                .new_slot       (cell_slot_in),
                .left_ins       (l_ins),
                .left_valid     (l_valid),
                .left_deadline  (l_deadline),
                .left_tag       (l_tag),
                .left_timeout   (l_timeout),
                .left_slot      (l_slot),
                .right_valid    (r_valid),
                .right_deadline (r_deadline),
                .right_tag      (r_tag),
                .right_timeout  (r_timeout),
                .right_slot     (r_slot),
                .valid          (c_valid[gi]),
                .deadline       (c_deadline[gi]),
                .tag            (c_tag[gi]),
                .timeout        (c_timeout[gi]),
                .slot           (c_slot[gi]),
                .ins            (c_ins[gi]),
                .due            (c_due[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            npop_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            npop_reg      <= npop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        now_reg        <= now_next;
        delay_reg      <= delay_next;
        prod_reg       <= prod_next;
        tag_reg        <= tag_next;
        timeout_reg    <= timeout_next;
        handle_reg     <= handle_next;
        kind_reg       <= kind_next;
        handle_out_reg <= handle_out_next;
        etag_reg       <= etag_next;
        eto_reg        <= eto_next;
        last_reg       <= last_next;
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign timer_handle    = handle_out_reg;
    assign expired_tag     = etag_reg;
    assign expired_timeout = eto_reg;
    assign last            = last_reg;

endmodule

/* src/sdtq_cell.sv */
// One cell of the sorted timer chain: holds a single timer and trades it
// with its neighbors. Depends on sdtq_pkg.
module sdtq_cell #(
    parameter int TAG_WIDTH = 8,
    parameter int SLOT_W    = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sdtq_pkg::cell_ctrl_t  ctrl,
    input  logic [TAG_WIDTH-1:0]  new_tag,
    input  logic [SLOT_W-1:0]     new_slot,
    input  logic                  left_ins,
    input  logic                  left_valid,
    input  logic [63:0]           left_deadline,
    input  logic [TAG_WIDTH-1:0]  left_tag,
    input  logic                  left_timeout,
    input  logic [SLOT_W-1:0]     left_slot,
    input  logic                  right_valid,
    input  logic [63:0]           right_deadline,
    input  logic [TAG_WIDTH-1:0]  right_tag,
    input  logic                  right_timeout,
    input  logic [SLOT_W-1:0]     right_slot,
    output logic                  valid,
    output logic [63:0]           deadline,
    output logic [TAG_WIDTH-1:0]  tag,
    output logic                  timeout,
    output logic [SLOT_W-1:0]     slot,
    output logic                  ins,
    output logic                  due
);

    logic                 valid_reg, valid_next;
    logic [63:0]          deadline_reg, deadline_next;
    logic [TAG_WIDTH-1:0] tag_reg, tag_next;
    logic                 timeout_reg, timeout_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;

    // A timer with an equal deadline stays ahead of a newly inserted one.
    assign due = valid_reg && (deadline_reg <= ctrl.key);
    assign ins = !due;

    always_comb
    begin
        valid_next    = valid_reg;
        deadline_next = deadline_reg;
        tag_next      = tag_reg;
        timeout_next  = timeout_reg;
        slot_next     = slot_reg;
        case (ctrl.op)
            sdtq_pkg::OP_INSERT:
            begin
                if (ins && left_ins)
                begin
                    valid_next    = left_valid;
                    deadline_next = left_deadline;
                    tag_next      = left_tag;
                    timeout_next  = left_timeout;
                    slot_next     = left_slot;
                end
                else if (ins)
                begin
                    valid_next    = 1'b1;
                    deadline_next = ctrl.key;
                    tag_next      = new_tag;
                    timeout_next  = ctrl.timeout;
                    slot_next     = new_slot;
                end
            end
            sdtq_pkg::OP_DROP:
            begin
                if (valid_reg && (slot_reg == new_slot))
                    valid_next = 1'b0;
            end
            sdtq_pkg::OP_COMPACT:
            begin
                // A hole pulls in its right neighbor and so moves one cell right.
                if (!valid_reg && right_valid)
                begin
                    valid_next    = 1'b1;
                    deadline_next = right_deadline;
                    tag_next      = right_tag;
                    timeout_next  = right_timeout;
                    slot_next     = right_slot;
                end
                else if (!left_valid && valid_reg)
                    valid_next = 1'b0;
            end
            sdtq_pkg::OP_POP:
            begin
                valid_next    = right_valid;
                deadline_next = right_deadline;
                tag_next      = right_tag;
                timeout_next  = right_timeout;
                slot_next     = right_slot;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
        tag_reg      <= tag_next;
        timeout_reg  <= timeout_next;
        slot_reg     <= slot_next;
    end

    assign valid    = valid_reg;
    assign deadline = deadline_reg;
    assign tag      = tag_reg;
    assign timeout  = timeout_reg;
    assign slot     = slot_reg;

endmodule

/* test/tb_sorted_deadline_timer_queue.sv */
// Self-checking testbench for the sorted deadline timer queue.
// Depends on sdtq_pkg and sorted_deadline_timer_queue; the expected results
// come from a timer store kept inside this file.
module tb_sorted_deadline_timer_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS           = 16;
    localparam int QUIET_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 24;
    localparam int PRINT_LIMIT     = 30;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] handle;
        logic [7:0] tag;
        logic       timeout;
        logic       last;
    } timer_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [63:0] deadline;
    logic [31:0] delay_ms;
    logic [63:0] now;
    logic [7:0]  owner_tag;
    logic        timeout_path;
    logic [3:0]  handle;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [3:0]  timer_handle;
    logic [7:0]  expired_tag;
    logic        expired_timeout;
    logic        last;

    // Timer store as the block should see it.
    logic [63:0] model_deadline [SLOTS];
    logic [7:0]  model_tag      [SLOTS];
    logic        model_timeout  [SLOTS];
    bit          model_live     [SLOTS];
    logic [3:0]  model_order    [SLOTS];
    int          model_count = 0;

    timer_result_t pending_results[$];

    logic [63:0] wall_clock_us = 64'd1_000_000;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_off_len    = 0;
    bit hold_off_req    = 1'b0;

    int items_sent      = 0;
    int results_checked = 0;
    int timers_expired  = 0;
    int mismatches      = 0;

    sorted_deadline_timer_queue u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .deadline        (deadline),
        .delay_ms        (delay_ms),
        .now             (now),
        .owner_tag       (owner_tag),
        .timeout_path    (timeout_path),
        .handle          (handle),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .timer_handle    (timer_handle),
        .expired_tag     (expired_tag),
        .expired_timeout (expired_timeout),
        .last            (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void push_result(input logic [2:0] k, input logic [3:0] h,
                                        input logic [7:0] tag, input logic to,
                                        input logic is_last);
        timer_result_t r;
        r.kind    = k;
        r.handle  = h;
        r.tag     = tag;
        r.timeout = to;
        r.last    = is_last;
        pending_results.push_back(r);
    endfunction

    function automatic void remove_order_at(input int pos);
        int i;
        for (i = pos; i + 1 < model_count; i++)
            model_order[i] = model_order[i + 1];
        model_count--;
    endfunction

    function automatic bit timer_due(input logic [63:0] t_now);
        return model_count > 0 && t_now >= model_deadline[model_order[0]];
    endfunction

    // Updates the timer store for one accepted transaction and queues its results.
    function automatic void predict_timer_results(input logic [1:0] f,
            input logic [63:0] dl_in, input logic [31:0] dly, input logic [63:0] t_now,
            input logic [7:0] tag, input logic to, input logic [3:0] h);
        logic [63:0] dl;
        logic [3:0]  head;
        int slot;
        int pos;
        int n;
        int i;
        case (f)
            sdtq_pkg::FUNC_ARM_ABS, sdtq_pkg::FUNC_ARM_REL:
            begin
                dl = (f == sdtq_pkg::FUNC_ARM_ABS) ? dl_in : t_now + {32'd0, dly} * 64'd1000;
                slot = 0;
                while (slot < SLOTS && model_live[slot])
                    slot++;
                if (model_count >= SLOTS || slot >= SLOTS)
                    push_result(sdtq_pkg::KIND_FULL, 4'd0, 8'd0, 1'b0, 1'b1);
                else
                begin
                    model_deadline[slot] = dl;
                    model_tag[slot]      = tag;
                    model_timeout[slot]  = to;
                    model_live[slot]     = 1'b1;
                    // Equal deadlines keep arrival order, so stop only past them.
                    pos = 0;
                    while (pos < model_count && model_deadline[model_order[pos]] <= dl)
                        pos++;
                    for (i = model_count; i > pos; i--)
                        model_order[i] = model_order[i - 1];
                    model_order[pos] = 4'(slot);
                    model_count++;
                    push_result(sdtq_pkg::KIND_ARMED, 4'(slot), 8'd0, 1'b0, 1'b1);
                end
            end
            sdtq_pkg::FUNC_DROP:
            begin
                if (!model_live[h])
                    push_result(sdtq_pkg::KIND_ABSENT, h, 8'd0, 1'b0, 1'b1);
                else
                begin
                    for (pos = 0; pos < model_count; pos++)
                    begin
                        if (model_order[pos] == h)
                        begin
                            remove_order_at(pos);
                            break;
                        end
                    end
                    model_live[h] = 1'b0;
                    push_result(sdtq_pkg::KIND_DROPPED, h, 8'd0, 1'b0, 1'b1);
                end
            end
            default:
            begin
                n = 0;
                while (n < sdtq_pkg::MAX_OUT && timer_due(t_now))
                begin
                    head = model_order[0];
                    remove_order_at(0);
                    model_live[head] = 1'b0;
                    n++;
                    push_result(sdtq_pkg::KIND_EXPIRED, head, model_tag[head],
                                model_timeout[head],
                                !(n < sdtq_pkg::MAX_OUT && timer_due(t_now)));
                end
                if (n == 0)
                    push_result(sdtq_pkg::KIND_NONE, 4'd0, 8'd0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function automatic logic [3:0] pick_live_handle();
        int live_list[$];
        int i;
        for (i = 0; i < SLOTS; i++)
            if (model_live[i])
                live_list.push_back(i);
        if (live_list.size() == 0)
            return 4'($urandom_range(15));
        return 4'(live_list[$urandom_range(live_list.size() - 1)]);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
            report_mismatch($sformatf("result %0d %s expected 0x%0h got 0x%0h",
                                      results_checked, name, want, got));
    endtask

    // Offers one transaction, holding valid and payload until it is accepted.
    task automatic send_item(input logic [1:0] f, input logic [63:0] dl,
                             input logic [31:0] dly, input logic [63:0] t_now,
                             input logic [7:0] tag, input logic to, input logic [3:0] h);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        deadline     <= dl;
        delay_ms     <= dly;
        now          <= t_now;
        owner_tag    <= tag;
        timeout_path <= to;
        handle       <= h;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_timer_results(f, dl, dly, t_now, tag, to, h);
        items_sent++;
    endtask

    task automatic test_directed();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        send_item(sdtq_pkg::FUNC_POLL, rand64(), $urandom, 64'd0, 8'hFF, 1'b1, 4'hF);
        send_item(sdtq_pkg::FUNC_DROP, rand64(), $urandom, rand64(), 8'hFF, 1'b1, 4'd0);
        send_item(sdtq_pkg::FUNC_DROP, rand64(), $urandom, rand64(), 8'h00, 1'b0, 4'd15);
        send_item(sdtq_pkg::FUNC_ARM_ABS, 64'd0, 32'hFFFF_FFFF, rand64(), 8'hFF, 1'b1, 4'hF);
        send_item(sdtq_pkg::FUNC_ARM_ABS, '1, 32'd0, rand64(), 8'h00, 1'b0, 4'h0);
        // The relative deadline wraps past the top of the 64-bit range.
        send_item(sdtq_pkg::FUNC_ARM_REL, rand64(), 32'hFFFF_FFFF, '1, 8'hA5, 1'b1, 4'h5);
        send_item(sdtq_pkg::FUNC_ARM_REL, '1, 32'd0, 64'd0, 8'h5A, 1'b0, 4'hA);
        send_item(sdtq_pkg::FUNC_ARM_ABS, 64'd1000, $urandom, rand64(), 8'h11, 1'b1, 4'h3);
        send_item(sdtq_pkg::FUNC_ARM_ABS, 64'd1000, $urandom, rand64(), 8'h22, 1'b0, 4'hC);
        send_item(sdtq_pkg::FUNC_DROP, rand64(), $urandom, rand64(), 8'h33, 1'b1, 4'd1);
        send_item(sdtq_pkg::FUNC_DROP, rand64(), $urandom, rand64(), 8'h44, 1'b0, 4'd1);
        send_item(sdtq_pkg::FUNC_ARM_ABS, 64'd500, $urandom, rand64(), 8'h66, 1'b1, 4'h9);
        send_item(sdtq_pkg::FUNC_POLL, rand64(), $urandom, 64'd0, 8'h77, 1'b0, 4'h6);
        send_item(sdtq_pkg::FUNC_POLL, rand64(), $urandom, 64'd999, 8'h88, 1'b1, 4'h7);
        send_item(sdtq_pkg::FUNC_POLL, rand64(), $urandom, 64'd1000, 8'h99, 1'b0, 4'h8);
        send_item(sdtq_pkg::FUNC_DROP, rand64(), $urandom, rand64(), 8'hCC, 1'b1, 4'd2);
        send_item(sdtq_pkg::FUNC_POLL, rand64(), $urandom, '1, 8'hDD, 1'b0, 4'hB);
    endtask

    task automatic test_full_store();
        int i;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        for (i = 0; i < SLOTS; i++)
            send_item(sdtq_pkg::FUNC_ARM_ABS, 64'($urandom_range(5000)), $urandom, rand64(),
                      8'($urandom_range(255)), 1'($urandom_range(1)), 4'($urandom_range(15)));
        send_item(sdtq_pkg::FUNC_ARM_ABS, 64'd10, $urandom, rand64(), 8'hEE, 1'b1, 4'h1);
        send_item(sdtq_pkg::FUNC_ARM_REL, rand64(), 32'd3, 64'd7, 8'h12, 1'b0, 4'h2);
        send_item(sdtq_pkg::FUNC_DROP, rand64(), $urandom, rand64(), 8'h00, 1'b0, 4'd7);
        send_item(sdtq_pkg::FUNC_ARM_ABS, 64'd5000, $urandom, rand64(), 8'h34, 1'b1, 4'h3);
        // Every timer is due, so this poll returns the largest burst.
        send_item(sdtq_pkg::FUNC_POLL, rand64(), $urandom, '1, 8'h56, 1'b0, 4'h4);
    endtask

    task automatic test_receiver_hold_off();
        int i;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_off_len    = HOLD_OFF_CYCLES;
        hold_off_req    = 1'b1;
        for (i = 0; i < 12; i++)
            send_item(sdtq_pkg::FUNC_ARM_ABS, wall_clock_us - $urandom_range(2000), $urandom,
                      rand64(), 8'($urandom_range(255)), 1'($urandom_range(1)),
                      4'($urandom_range(15)));
        send_item(sdtq_pkg::FUNC_POLL, rand64(), $urandom, wall_clock_us,
                  8'($urandom_range(255)), 1'($urandom_range(1)), 4'($urandom_range(15)));
        for (i = 0; i < 4; i++)
            send_item(sdtq_pkg::FUNC_DROP, rand64(), $urandom, rand64(),
                      8'($urandom_range(255)), 1'($urandom_range(1)),
                      4'($urandom_range(15)));
    endtask

    // Mostly timers near the running clock, drops of live handles and polls that
    // advance the clock; about one item in ten carries raw random values instead.
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        logic [63:0] dl;
        logic [63:0] t_now;
        logic [31:0] dly;
        logic [3:0]  h;
        int pick;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        repeat (n_items)
        begin
            pick  = $urandom_range(99);
            dl    = rand64();
            t_now = rand64();
            dly   = $urandom;
            h     = 4'($urandom_range(15));
            if (pick < 22)
            begin
                if ($urandom_range(9) != 0)
                    dl = wall_clock_us + $urandom_range(6000);
                send_item(sdtq_pkg::FUNC_ARM_ABS, dl, dly, t_now, 8'($urandom_range(255)),
                          1'($urandom_range(1)), h);
            end
            else if (pick < 42)
            begin
                if ($urandom_range(9) != 0)
                begin
                    dly   = $urandom_range(6);
                    t_now = wall_clock_us;
                end
                send_item(sdtq_pkg::FUNC_ARM_REL, dl, dly, t_now, 8'($urandom_range(255)),
                          1'($urandom_range(1)), h);
            end
            else if (pick < 62)
            begin
                if ($urandom_range(9) != 0)
                    h = pick_live_handle();
                send_item(sdtq_pkg::FUNC_DROP, dl, dly, t_now, 8'($urandom_range(255)),
                          1'($urandom_range(1)), h);
            end
            else
            begin
                if ($urandom_range(9) != 0)
                begin
                    wall_clock_us = wall_clock_us + $urandom_range(2500);
                    t_now = wall_clock_us;
                end
                send_item(sdtq_pkg::FUNC_POLL, dl, dly, t_now, 8'($urandom_range(255)),
                          1'($urandom_range(1)), h);
            end
        end
    endtask

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                stall_left   = hold_off_len;
                hold_off_req = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        timer_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result of kind %0d with nothing expected", kind));
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, kind);
                check_field("timer_handle", want.handle, timer_handle);
                check_field("expired_tag", want.tag, expired_tag);
                check_field("expired_timeout", want.timeout, expired_timeout);
                check_field("last", want.last, last);
                if (want.kind == sdtq_pkg::KIND_EXPIRED)
                    timers_expired++;
            end
            results_checked++;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        func         <= sdtq_pkg::FUNC_POLL;
        deadline     <= '0;
        delay_ms     <= '0;
        now          <= '0;
        owner_tag    <= '0;
        timeout_path <= 1'b0;
        handle       <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_store();
        test_receiver_hold_off();
        test_random_traffic(76, 0, 0);
        test_random_traffic(76, 72, 0);
        test_random_traffic(76, 0, 72);
        test_random_traffic(76, 36, 36);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d transactions in: directed cases, a full store, a long output",
                 items_sent);
        $display("stall and random traffic; %0d results checked, %0d expired timers.",
                 results_checked, timers_expired);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sorted_deadline_timer_queue.f */
src/sdtq_pkg.sv
src/sdtq_cell.sv
src/sorted_deadline_timer_queue.sv
test/tb_sorted_deadline_timer_queue.sv
